// File: rtl/reservoir_sampler_unit_macros.svh
// Assertion macros shared by the checker.
`ifndef RESERVOIR_SAMPLER_UNIT_MACROS_SVH
`define RESERVOIR_SAMPLER_UNIT_MACROS_SVH

// same-cycle implication
`define RSV_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RSV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/rsv_pkg.sv
package rsv_pkg;

  localparam int CFG_W     = 7;
  localparam int SLOT_W    = 6;
  localparam int SEEN_W    = 32;
  localparam int VAL_W     = 64;
  localparam int RND_W     = 32;
  localparam int DIV_STEPS = RND_W;

  localparam logic [CFG_W-1:0]  CFG_SIZE_RST = 7'd64;
  localparam logic [SEEN_W-1:0] SEEN_MAX     = 32'hFFFF_FFFF;

  localparam logic OP_OFFER = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef struct packed {
    logic             opcode;
    logic [VAL_W-1:0] item_value;
    logic [RND_W-1:0] random_word;
  } in_req_t;

  typedef struct packed {
    logic [VAL_W-1:0]  sample_value;
    logic [SLOT_W-1:0] slot_index;
    logic              last_flag;
    logic              empty_flag;
  } out_req_t;

endpackage

// File: rtl/rsv_ram.sv
module rsv_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/rsv_divider.sv
module rsv_divider (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [rsv_pkg::RND_W-1:0]  dividend,
  input  logic [rsv_pkg::RND_W:0]    divisor,
  output logic                       done,
  output logic [rsv_pkg::RND_W:0]    remainder
);

  import rsv_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [RND_W-1:0] quo_r, quo_nxt;
  logic [RND_W:0]   rem_r, rem_nxt;
  logic [RND_W:0]   den_r, den_nxt;
  logic [RND_W+1:0] trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    trial    = {rem_r, quo_r[RND_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DIV_STEPS - 1);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      den_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = (RND_W+1)'(trial - {1'b0, den_r});
      end else begin
        rem_nxt = trial[RND_W:0];
      end
      quo_nxt = {quo_r[RND_W-2:0], 1'b0};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

// File: rtl/reservoir_sampler_unit.sv
// Offer while the reservoir fills: the item is written straight into the store. Offer after it is
// full: waits on the serial modulo unit (32 quotient-bit steps, plus start and write-back).
// Drain: each result passes the store's registered read port (S_RD, then S_LD); the last
// result sits in the output register while the next request is taken.
// Reset (synchronous, rst_n low) clears the seen count, sets reservoir_size to 64
// and empties the output register; slot contents are undefined until written.
module reservoir_sampler_unit #(
  parameter int MAX_SAMPLES = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  rsv_pkg::in_req_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output rsv_pkg::out_req_t             out_data,
  input  logic                          cfg_we,
  input  logic [rsv_pkg::CFG_W-1:0]     cfg_wdata
);

  import rsv_pkg::*;

  localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam logic [CFG_W-1:0] MAX_SZ = CFG_W'(MAX_SAMPLES);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_RD   = 4'b0100,
    S_LD   = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CFG_W-1:0]    size_r, size_nxt;
  logic [SEEN_W-1:0]   seen_r, seen_nxt;
  logic [VAL_W-1:0]    item_r, item_nxt;
  logic [SLOT_W-1:0]   k_r, k_nxt;
  logic [CFG_W-1:0]    n_r, n_nxt;
  logic                empty_r, empty_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_req_t            out_r, out_nxt;

  logic [CFG_W-1:0]    eff;
  logic                fill;
  logic [SEEN_W-1:0]   seen_inc;
  logic                in_acc;
  logic                out_free;
  logic                last;
  logic                div_start;
  logic                div_done;
  logic [RND_W:0]      div_rem;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [VAL_W-1:0]    ram_wdata;
  logic                ram_re;
  logic [VAL_W-1:0]    ram_rdata;

  always_comb begin
    if (size_r == '0) begin
      eff = CFG_W'(1);
    end else if (size_r > MAX_SZ) begin
      eff = MAX_SZ;
    end else begin
      eff = size_r;
    end
  end

  assign fill      = seen_r < SEEN_W'(eff);
  assign seen_inc  = (seen_r == SEEN_MAX) ? seen_r : seen_r + SEEN_W'(1);
  assign in_acc    = in_valid && (state_r == S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign last      = empty_r || ((CFG_W'(k_r) + CFG_W'(1)) == n_r);
  assign div_start = in_acc && (in_data.opcode == OP_OFFER) && !fill;

  always_comb begin
    state_nxt     = state_r;
    size_nxt      = cfg_we ? cfg_wdata : size_r;
    seen_nxt      = seen_r;
    item_nxt      = item_r;
    k_nxt         = k_r;
    n_nxt         = n_r;
    empty_nxt     = empty_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    ram_we        = 1'b0;
    ram_waddr     = seen_r[AW-1:0];
    ram_wdata     = in_data.item_value;
    ram_re        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_data.opcode == OP_OFFER) begin
            if (fill) begin
              ram_we   = 1'b1;
              seen_nxt = seen_inc;
            end else begin
              item_nxt  = in_data.item_value;
              state_nxt = S_DIV;
            end
          end else begin
            seen_nxt  = '0;
            k_nxt     = '0;
            n_nxt     = fill ? seen_r[CFG_W-1:0] : eff;
            empty_nxt = (seen_r == '0);
            state_nxt = (seen_r == '0) ? S_LD : S_RD;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          ram_waddr = div_rem[AW-1:0];
          ram_wdata = item_r;
          ram_we    = div_rem < (RND_W+1)'(eff);
          seen_nxt  = seen_inc;
          state_nxt = S_IDLE;
        end
      end
      S_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_LD;
      end
      S_LD: begin
        if (out_free) begin
          out_valid_nxt        = 1'b1;
          out_nxt.sample_value = empty_r ? '0 : ram_rdata;
          out_nxt.slot_index   = k_r;
          out_nxt.last_flag    = last;
          out_nxt.empty_flag   = empty_r;
          if (last) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + SLOT_W'(1);
            state_nxt = S_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      size_r      <= CFG_SIZE_RST;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
      empty_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      size_r      <= size_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
      empty_r     <= empty_nxt;
    end
    item_r <= item_nxt;
    k_r    <= k_nxt;
    n_r    <= n_nxt;
    out_r  <= out_nxt;
  end

  rsv_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (in_data.random_word),
    .divisor   ({1'b0, seen_r} + (RND_W+1)'(1)),
    .done      (div_done),
    .remainder (div_rem)
  );

  rsv_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_SAMPLES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (k_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: rtl/rsv_checker.sv
`include "reservoir_sampler_unit_macros.svh"

module rsv_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input rsv_pkg::in_req_t          in_data,
  input logic                      out_valid,
  input logic                      out_stall,
  input rsv_pkg::out_req_t         out_data
);

  import rsv_pkg::*;

  logic in_offer;

  assign in_offer = in_valid && !in_stall && (in_data.opcode == OP_OFFER);

  `RSV_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
  `RSV_ASSERT_NOW(a_empty_form, clk, rst_n, out_valid && out_data.empty_flag, out_data.last_flag && (out_data.slot_index == '0) && (out_data.sample_value == '0), "bad empty result")
  `RSV_ASSERT_NOW(a_drain_busy, clk, rst_n, out_valid && !out_data.last_flag, in_stall, "request taken mid-drain")
  `RSV_ASSERT_NEXT(a_offer_quiet, clk, rst_n, in_offer && !out_valid, !out_valid, "offer produced a result")

endmodule

bind reservoir_sampler_unit rsv_checker u_rsv_checker (.*);

// File: verif/tb_reservoir_sampler_unit.sv
`timescale 1ns / 100ps

module tb_reservoir_sampler_unit;
  import rsv_pkg::*;

  localparam int MAX_SAMPLES   = 64;
  localparam int RUN_ITEMS     = 320;
  localparam int SETTLE_CYCLES = 48;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 2000000;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  in_req_t           in_data;
  logic              out_valid;
  logic              out_stall;
  out_req_t          out_data;
  logic              cfg_we;
  logic [CFG_W-1:0]  cfg_wdata;

  class sampler_scoreboard;
    logic [VAL_W-1:0]  slots [MAX_SAMPLES];
    logic [SEEN_W-1:0] seen;
    logic [CFG_W-1:0]  size_reg;
    out_req_t          pending [$];
    int                errors;

    function new();
      foreach (slots[i]) slots[i] = '0;
      seen     = '0;
      size_reg = CFG_SIZE_RST;
      errors   = 0;
    endfunction

    function int eff_size();
      if (size_reg == '0) return 1;
      if (size_reg > MAX_SAMPLES) return MAX_SAMPLES;
      return int'(size_reg);
    endfunction

    function void note_request(in_req_t req);
      int                s;
      int                n;
      logic [RND_W:0]    modulus;
      logic [RND_W:0]    pick;
      out_req_t          res;
      s = eff_size();
      if (req.opcode == OP_OFFER) begin
        if (seen < SEEN_W'(s)) begin
          slots[seen[SLOT_W-1:0]] = req.item_value;
        end else begin
          modulus = {1'b0, seen} + 1'b1;
          pick    = {1'b0, req.random_word} % modulus;
          if (pick < s) slots[pick[SLOT_W-1:0]] = req.item_value;
        end
        if (seen != SEEN_MAX) seen++;
      end else begin
        n    = (seen < SEEN_W'(s)) ? int'(seen) : s;
        seen = '0;
        if (n == 0) begin
          res.sample_value = '0;
          res.slot_index   = '0;
          res.last_flag    = 1'b1;
          res.empty_flag   = 1'b1;
          pending.insert(pending.size(), res);
        end else begin
          for (int k = 0; k < n; k++) begin
            res.sample_value = slots[k];
            res.slot_index   = SLOT_W'(k);
            res.last_flag    = (k == n - 1);
            res.empty_flag   = 1'b0;
            pending.insert(pending.size(), res);
          end
        end
      end
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 50) $display("mismatch @%0t: %s", $time, msg);
    endtask

    task check_result(out_req_t got);
      out_req_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected result slot %0d value %h",
                                  got.slot_index, got.sample_value));
        return;
      end
      want = pending.pop_front();
      if (got.sample_value !== want.sample_value)
        report_mismatch($sformatf("sample_value %h, want %h",
                                  got.sample_value, want.sample_value));
      if (got.slot_index !== want.slot_index)
        report_mismatch($sformatf("slot_index %0d, want %0d",
                                  got.slot_index, want.slot_index));
      if (got.last_flag !== want.last_flag)
        report_mismatch($sformatf("last_flag %b, want %b", got.last_flag, want.last_flag));
      if (got.empty_flag !== want.empty_flag)
        report_mismatch($sformatf("empty_flag %b, want %b",
                                  got.empty_flag, want.empty_flag));
    endtask
  endclass

  sampler_scoreboard sb = new();
  int cycles = 0;
  int sent;
  int burst_left;

  reservoir_sampler_unit #(.MAX_SAMPLES(MAX_SAMPLES)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // receiver: random stall segments, one long hold-off during a big drain
  initial begin : receiver
    int  left;
    int  pct;
    int  hold_left;
    bit  held;
    out_stall = 1'b0;
    left      = 0;
    pct       = 0;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && sb.pending.size() > 32) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (left == 0) begin
          left = $urandom_range(8, 60);
          case ($urandom_range(0, 2))
            0: pct = 0;
            1: pct = 30;
            default: pct = 75;
          endcase
        end
        left--;
        out_stall <= ($urandom_range(0, 99) < pct);
      end
    end
  end

  function automatic logic [VAL_W-1:0] rand_id();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [RND_W-1:0] rand_word();
    case ($urandom_range(0, 5))
      0, 1, 2: return $urandom();
      3:       return $urandom_range(0, 15);
      4:       return $urandom_range(0, 127);
      default: return $urandom_range(0, 1) ? '1 : '0;
    endcase
  endfunction

  function automatic in_req_t offer_req(logic [VAL_W-1:0] v, logic [RND_W-1:0] r);
    in_req_t q;
    q.opcode      = OP_OFFER;
    q.item_value  = v;
    q.random_word = r;
    return q;
  endfunction

  function automatic in_req_t drain_req();
    in_req_t q;
    q.opcode      = OP_DRAIN;
    q.item_value  = rand_id();
    q.random_word = $urandom();
    return q;
  endfunction

  // called at a rising edge; returns at the edge where the request is taken
  task automatic send(in_req_t req);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    sb.note_request(req);
    sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_size(logic [CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    sb.size_reg = v;
    cfg_we <= 1'b0;
  endtask

  task automatic run_round(int n_offers);
    repeat (n_offers) send(offer_req(rand_id(), rand_word()));
    send(drain_req());
  endtask

  initial begin
    int sz;
    int eff;
    int rounds;
    int n;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    sent       = 0;
    burst_left = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset size, empty drains around a partial fill
    send(drain_req());
    send(offer_req('0, '0));
    send(offer_req('1, '1));
    send(offer_req(64'hA5A5_5A5A_0F0F_F0F0, 32'h8000_0000));
    send(drain_req());
    send(drain_req());
    wait_idle();

    // single slot: replace hit, then two misses
    write_size(7'd1);
    send(offer_req(64'h0123_4567_89AB_CDEF, $urandom()));
    send(offer_req(64'hFEDC_BA98_7654_3210, 32'd0));
    send(offer_req(64'h1111_2222_3333_4444, 32'd1));
    send(offer_req(64'h5555_6666_7777_8888, '1));
    send(drain_req());
    wait_idle();

    // zero size behaves as one
    write_size(7'd0);
    send(offer_req(rand_id(), rand_word()));
    send(offer_req(rand_id(), 32'd0));
    send(drain_req());
    wait_idle();

    // oversize clamps to full depth; the next offer is held off by in_stall during the long hold-off
    write_size(7'd127);
    run_round(70);
    run_round(20);

    while (sent < RUN_ITEMS) begin
      wait_idle();
      case ($urandom_range(0, 7))
        0:       sz = 0;
        1:       sz = $urandom_range(65, 127);
        2:       sz = $urandom_range(9, 64);
        default: sz = $urandom_range(1, 8);
      endcase
      write_size(sz[CFG_W-1:0]);
      eff = (sz == 0) ? 1 : ((sz > MAX_SAMPLES) ? MAX_SAMPLES : sz);
      rounds = $urandom_range(1, 4);
      repeat (rounds) begin
        if (sent < RUN_ITEMS) begin
          n = (eff > 12) ? $urandom_range(0, eff + 8) : $urandom_range(0, 3 * eff + 3);
          if (n > RUN_ITEMS - sent - 1) n = RUN_ITEMS - sent - 1;
          run_round(n);
        end
      end
    end
    wait_idle();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
